// ----- hw/rtl/pipas_pkg.sv -----
package pipas_pkg;

	// Flags that travel with each bearing from front to back
	typedef struct packed {
		logic first;
		logic last;
	} pipas_tag_t;

	// Depth of the bearing queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// atan(2^-i) in units of 2^32 per full turn
	function automatic logic [31:0] atan_turn32(input int i);
		logic [31:0] t;
		unique case (i)
			0:  t = 32'h20000000;
			1:  t = 32'h12E4051E;
			2:  t = 32'h09FB385B;
			3:  t = 32'h051111D4;
			4:  t = 32'h028B0D43;
			5:  t = 32'h0145D7E1;
			6:  t = 32'h00A2F61E;
			7:  t = 32'h00517C55;
			8:  t = 32'h0028BE53;
			9:  t = 32'h00145F2F;
			10: t = 32'h000A2F98;
			11: t = 32'h000517CC;
			12: t = 32'h00028BE6;
			13: t = 32'h000145F3;
			14: t = 32'h0000A2F9;
			15: t = 32'h0000517C;
			16: t = 32'h000028BE;
			17: t = 32'h0000145F;
			18: t = 32'h00000A2F;
			19: t = 32'h00000517;
			20: t = 32'h0000028B;
			21: t = 32'h00000145;
			22: t = 32'h000000A2;
			23: t = 32'h00000051;
			24: t = 32'h00000028;
			25: t = 32'h00000014;
			26: t = 32'h0000000A;
			27: t = 32'h00000005;
			28: t = 32'h00000002;
			29: t = 32'h00000001;
			default: t = 32'h00000000;
		endcase
		return t;
	endfunction

endpackage

// ----- hw/rtl/pipas_front.sv -----
module pipas_front #(
	parameter int COORD_BITS = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] vertex_x,
	input  logic signed [COORD_BITS-1:0] vertex_y,
	input  logic                         last_vertex,
	output logic                         push,
	input  logic                         queue_full,
	output logic [ANGLE_BITS-1:0]        bearing,
	output pipas_pkg::pipas_tag_t        tag
);

	localparam int DW  = COORD_BITS + 1;
	localparam int PRE = ANGLE_BITS + 2;
	localparam int W   = COORD_BITS + ANGLE_BITS + 5;
	localparam logic [ANGLE_BITS-1:0] HALF = {1'b1, {(ANGLE_BITS-1){1'b0}}};

	logic                         adv;
	logic                         accept;
	logic                         open_q;
	logic signed [COORD_BITS-1:0] held_px_q;
	logic signed [COORD_BITS-1:0] held_py_q;
	logic signed [COORD_BITS-1:0] px;
	logic signed [COORD_BITS-1:0] py;

	// Offset stage
	logic                 v_s1;
	logic signed [DW-1:0] dx_s1;
	logic signed [DW-1:0] dy_s1;
	logic                 first_s1;
	logic                 last_s1;

	// Rotation stages: index 0 is the prerotated vector, index k+1 follows iteration k
	logic [ANGLE_BITS:0]         cv_sn;
	logic [ANGLE_BITS:0]         cfirst_sn;
	logic [ANGLE_BITS:0]         clast_sn;
	logic [ANGLE_BITS:0]         czero_sn;
	logic signed [W-1:0]         cx_sn [ANGLE_BITS+1];
	logic signed [W-1:0]         cy_sn [ANGLE_BITS+1];
	logic [ANGLE_BITS-1:0]       cz_sn [ANGLE_BITS+1];

	logic signed [DW:0] dxe;
	logic signed [DW:0] dye;
	logic signed [DW:0] xsel;
	logic signed [DW:0] ysel;

	// Hold the whole pipe when the tail beat cannot enter the queue
	assign adv      = !(cv_sn[ANGLE_BITS] && queue_full);
	assign in_stall = !adv;
	assign accept   = in_valid && adv;
	assign push     = cv_sn[ANGLE_BITS] && !queue_full;

	// Track the open query and its point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
		end else if (accept) begin
			open_q <= !last_vertex;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !open_q) begin
			held_px_q <= point_x;
			held_py_q <= point_y;
		end
	end

	assign px = open_q ? held_px_q : point_x;
	assign py = open_q ? held_py_q : point_y;

	// Offset from the test point
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1    <= {vertex_x[COORD_BITS-1], vertex_x} - {px[COORD_BITS-1], px};
			dy_s1    <= {vertex_y[COORD_BITS-1], vertex_y} - {py[COORD_BITS-1], py};
			first_s1 <= !open_q;
			last_s1  <= last_vertex;
		end
	end

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			cv_sn <= '0;
		end else if (adv) begin
			v_s1  <= in_valid;
			cv_sn <= {cv_sn[ANGLE_BITS-1:0], v_s1};
		end
	end

	// Prerotate by a half turn when x is negative
	assign dxe  = {dx_s1[DW-1], dx_s1};
	assign dye  = {dy_s1[DW-1], dy_s1};
	assign xsel = dx_s1[DW-1] ? -dxe : dxe;
	assign ysel = dx_s1[DW-1] ? -dye : dye;

	always_ff @(posedge clk) begin
		if (adv) begin
			cx_sn[0]  <= {{(W-DW-1-PRE){xsel[DW]}}, xsel, {PRE{1'b0}}};
			cy_sn[0]  <= {{(W-DW-1-PRE){ysel[DW]}}, ysel, {PRE{1'b0}}};
			cz_sn[0]  <= dx_s1[DW-1] ? HALF : '0;
			czero_sn <= {czero_sn[ANGLE_BITS-1:0], (dx_s1 == '0) && (dy_s1 == '0)};
			cfirst_sn <= {cfirst_sn[ANGLE_BITS-1:0], first_s1};
			clast_sn  <= {clast_sn[ANGLE_BITS-1:0], last_s1};
		end
	end

	// One vectoring iteration per stage
	for (genvar k = 0; k < ANGLE_BITS; k++) begin : g_iter
		localparam int SH = 32 - ANGLE_BITS;
		localparam logic [32:0] ROUNDED =
			({1'b0, pipas_pkg::atan_turn32(k)} + (33'd1 << (SH - 1))) >> SH;
		localparam logic [ANGLE_BITS-1:0] STEP = ROUNDED[ANGLE_BITS-1:0];

		logic signed [W-1:0] xs;
		logic signed [W-1:0] ys;

		assign xs = cx_sn[k] >>> k;
		assign ys = cy_sn[k] >>> k;

		always_ff @(posedge clk) begin
			if (adv) begin
				if (!cy_sn[k][W-1]) begin
					cx_sn[k+1] <= cx_sn[k] + ys;
					cy_sn[k+1] <= cy_sn[k] - xs;
					cz_sn[k+1] <= cz_sn[k] + STEP;
				end else begin
					cx_sn[k+1] <= cx_sn[k] - ys;
					cy_sn[k+1] <= cy_sn[k] + xs;
					cz_sn[k+1] <= cz_sn[k] - STEP;
				end
			end
		end
	end

	// A vertex on the point has bearing zero
	assign bearing   = czero_sn[ANGLE_BITS] ? '0 : cz_sn[ANGLE_BITS];
	assign tag.first = cfirst_sn[ANGLE_BITS];
	assign tag.last  = clast_sn[ANGLE_BITS];

endmodule

// ----- hw/rtl/pipas_queue.sv -----
module pipas_queue #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             nonempty,
	output logic [WIDTH-1:0] head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full     = (count_q == FULL_CNT);
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_ptr_q];

	// Store beat at the write pointer
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) pop |-> nonempty)
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_CNT)
		else $error("queue count out of range");

endmodule

// ----- hw/rtl/pipas_back.sv -----
module pipas_back #(
	parameter int ANGLE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  nonempty,
	input  logic [ANGLE_BITS-1:0] bearing,
	input  pipas_pkg::pipas_tag_t tag,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  inside_res
);

	localparam logic signed [31:0] HALF_POS = 32'sd1 <<< (ANGLE_BITS - 1);
	localparam logic signed [31:0] HALF_NEG = -HALF_POS;

	logic [ANGLE_BITS-1:0]        first_q;
	logic [ANGLE_BITS-1:0]        prev_q;
	logic signed [31:0]           sum_q;
	logic                         out_valid_q;
	logic                         inside_q;

	logic                         v_s1;
	logic signed [ANGLE_BITS:0]   delta_s1;
	logic                         first_s1;
	logic                         last_s1;

	logic [ANGLE_BITS-1:0]        fb;
	logic [ANGLE_BITS-1:0]        pb;
	logic [ANGLE_BITS-1:0]        d_step;
	logic [ANGLE_BITS-1:0]        d_close;
	logic signed [ANGLE_BITS:0]   delta;
	logic                         s1_go;
	logic signed [31:0]           sum_new;

	// Wrapped differences: two's complement of the angle width
	assign fb      = tag.first ? bearing : first_q;
	assign pb      = tag.first ? bearing : prev_q;
	assign d_step  = bearing - pb;
	assign d_close = fb - bearing;
	assign delta   = {d_step[ANGLE_BITS-1], d_step}
	               + (tag.last ? {d_close[ANGLE_BITS-1], d_close} : '0);

	// Commit the staged beat; a closing beat needs the output register free
	assign s1_go = v_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign pop   = nonempty && (!v_s1 || s1_go);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (pop) begin
			v_s1 <= 1'b1;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	// Take a bearing from the queue
	always_ff @(posedge clk) begin
		if (pop) begin
			first_q  <= fb;
			prev_q   <= bearing;
			delta_s1 <= delta;
			first_s1 <= tag.first;
			last_s1  <= tag.last;
		end
	end

	// Accumulate the angle sum
	assign sum_new = (first_s1 ? 32'sd0 : sum_q)
	               + {{(32-ANGLE_BITS-1){delta_s1[ANGLE_BITS]}}, delta_s1};

	always_ff @(posedge clk) begin
		if (s1_go) begin
			sum_q <= sum_new;
		end
		if (s1_go && last_s1) begin
			inside_q <= (sum_new >= HALF_POS) || (sum_new <= HALF_NEG);
		end
	end

	// Hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign inside_res = inside_q;

endmodule

// ----- hw/rtl/point_in_polygon_angle_sum_top.sv -----
// Point-in-polygon test by winding angle sum. A query is a run of vertex beats
// closed by last_vertex; the test point is taken from the first beat of each
// query. One vertex beat is accepted per cycle while in_stall is low. Each
// bearing comes out of a pipelined CORDIC with one stage per iteration, so a
// vertex passes the offset, prerotation and iteration registers of the front
// end, then a four-entry queue and two register stages in the back end, which
// adds one difference per cycle unless a closing beat waits on out_stall. One
// result beat (inside_res) leaves for every last_vertex beat.
module point_in_polygon_angle_sum_top #(
	parameter int COORD_BITS = 16,
	parameter int ANGLE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] vertex_x,
	input  logic signed [COORD_BITS-1:0] vertex_y,
	input  logic                         last_vertex,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         inside_res
);

	localparam int QW = ANGLE_BITS + 2;

	logic                  push;
	logic                  queue_full;
	logic                  pop;
	logic                  nonempty;
	logic [ANGLE_BITS-1:0] front_bearing;
	pipas_pkg::pipas_tag_t front_tag;
	logic [QW-1:0]         head;
	logic [ANGLE_BITS-1:0] back_bearing;
	pipas_pkg::pipas_tag_t back_tag;

	// Offset and bearing per vertex
	pipas_front #(
		.COORD_BITS (COORD_BITS),
		.ANGLE_BITS (ANGLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.point_x     (point_x),
		.point_y     (point_y),
		.vertex_x    (vertex_x),
		.vertex_y    (vertex_y),
		.last_vertex (last_vertex),
		.push        (push),
		.queue_full  (queue_full),
		.bearing     (front_bearing),
		.tag         (front_tag)
	);

	// Decouple front and back
	pipas_queue #(
		.WIDTH (QW),
		.DEPTH (pipas_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({front_tag, front_bearing}),
		.full      (queue_full),
		.pop       (pop),
		.nonempty  (nonempty),
		.head      (head)
	);

	assign back_bearing = head[ANGLE_BITS-1:0];
	assign back_tag     = head[QW-1:ANGLE_BITS];

	// Angle sum and decision
	pipas_back #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.nonempty   (nonempty),
		.bearing    (back_bearing),
		.tag        (back_tag),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.inside_res (inside_res)
	);

endmodule

// ----- tb/point_in_polygon_angle_sum_top_tb.sv -----
`timescale 1ns / 100ps

module point_in_polygon_angle_sum_top_tb;

	localparam int COORD_BITS = 16;
	localparam int ANGLE_BITS = 16;
	localparam int PRESCALE   = ANGLE_BITS + 2;
	localparam int RANDOM_VERTICES = 1050;
	localparam longint COORD_MAX = (64'sd1 <<< (COORD_BITS - 1)) - 1;
	localparam longint COORD_MIN = -(64'sd1 <<< (COORD_BITS - 1));
	localparam logic [31:0] HALF_TURN = 32'd1 << (ANGLE_BITS - 1);

	// atan(2^-i), 2^32 units per full turn
	localparam logic [31:0] ATAN_TURN [0:15] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
	};

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [ANGLE_BITS-1:0] bearing_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_stall;
	coord_t point_x = '0;
	coord_t point_y = '0;
	coord_t vertex_x = '0;
	coord_t vertex_y = '0;
	logic   last_vertex = 1'b0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	logic   inside_res;

	// Winding tracker state
	bit       in_query = 1'b0;
	coord_t   anchor_x = '0;
	coord_t   anchor_y = '0;
	bearing_t start_bearing = '0;
	bearing_t last_bearing = '0;
	logic [31:0] turn_sum = '0;

	bit inside_expected [$];
	int fail_count = 0;
	int vertices_sent = 0;
	bit calm = 1'b0;

	point_in_polygon_angle_sum_top #(
		.COORD_BITS(COORD_BITS),
		.ANGLE_BITS(ANGLE_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.point_x(point_x),
		.point_y(point_y),
		.vertex_x(vertex_x),
		.vertex_y(vertex_y),
		.last_vertex(last_vertex),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.inside_res(inside_res)
	);

	always #6 clk = ~clk;

	// Vectoring CORDIC: bearing of the offset (dx, dy) in binary angle units
	function automatic bearing_t cordic_atan2(input longint dx, input longint dy);
		longint x, y, nx, ny;
		bearing_t z;
		logic [31:0] rounded;
		int i;
		if (dx == 0 && dy == 0)
			return '0;
		x = dx <<< PRESCALE;
		y = dy <<< PRESCALE;
		z = '0;
		if (x < 0) begin
			x = -x;
			y = -y;
			z = HALF_TURN[ANGLE_BITS-1:0];
		end
		for (i = 0; i < ANGLE_BITS; i++) begin
			rounded = (ATAN_TURN[i] + (32'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
			if (y >= 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z = z + rounded[ANGLE_BITS-1:0];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z = z - rounded[ANGLE_BITS-1:0];
			end
			x = nx;
			y = ny;
		end
		return z;
	endfunction

	// Signed turn from one bearing to the next, in [-half, half)
	function automatic logic [31:0] bearing_step(input bearing_t from_b, input bearing_t to_b);
		bearing_t d;
		d = to_b - from_b;
		return {{(32 - ANGLE_BITS){d[ANGLE_BITS-1]}}, d};
	endfunction

	function automatic coord_t clamp_coord(input longint v);
		if (v > COORD_MAX)
			return coord_t'(COORD_MAX);
		if (v < COORD_MIN)
			return coord_t'(COORD_MIN);
		return coord_t'(v);
	endfunction

	// Advance the winding tracker by one accepted vertex beat
	task automatic track_winding(input coord_t px, input coord_t py, input coord_t vx,
			input coord_t vy, input bit lst);
		bearing_t b;
		logic [31:0] mag;
		if (!in_query) begin
			anchor_x = px;
			anchor_y = py;
			b = cordic_atan2(longint'(vx) - longint'(px), longint'(vy) - longint'(py));
			start_bearing = b;
			last_bearing = b;
			turn_sum = '0;
			in_query = 1'b1;
		end else begin
			b = cordic_atan2(longint'(vx) - longint'(anchor_x),
				longint'(vy) - longint'(anchor_y));
			turn_sum = turn_sum + bearing_step(last_bearing, b);
			last_bearing = b;
		end
		if (lst) begin
			turn_sum = turn_sum + bearing_step(b, start_bearing);
			in_query = 1'b0;
			mag = turn_sum[31] ? (~turn_sum + 32'd1) : turn_sum;
			inside_expected.push_back(mag >= HALF_TURN);
		end
	endtask

	// Send one vertex beat and hold it until accepted
	task automatic send_vertex(input coord_t px, input coord_t py, input coord_t vx,
			input coord_t vy, input bit lst);
		while (!calm && $urandom_range(0, 99) < 10) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= px;
		point_y <= py;
		vertex_x <= vx;
		vertex_y <= vy;
		last_vertex <= lst;
		do
			@(posedge clk);
		while (in_stall);
		track_winding(px, py, vx, vy, lst);
		vertices_sent++;
	endtask

	// Walk the quadrants around a random point, zero to three turns either way
	task automatic send_winding_query();
		coord_t px, py;
		int n, turns, r, q;
		longint ax, ay;
		bit ccw;
		px = coord_t'($urandom);
		py = coord_t'($urandom);
		n = $urandom_range(1, 16);
		turns = $urandom_range(0, 3);
		ccw = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 2))
			0: r = $urandom_range(1, 8);
			1: r = $urandom_range(1, 2000);
			default: r = $urandom_range(1, 70000);
		endcase
		for (int k = 0; k < n; k++) begin
			q = (k * 4 * turns) / n;
			if (!ccw)
				q = -q;
			ax = longint'($urandom_range(0, r));
			ay = longint'($urandom_range(0, r));
			if ((q & 3) == 1 || (q & 3) == 2)
				ax = -ax;
			if ((q & 3) >= 2)
				ay = -ay;
			send_vertex(k == 0 ? px : coord_t'($urandom), k == 0 ? py : coord_t'($urandom),
				clamp_coord(longint'(px) + ax), clamp_coord(longint'(py) + ay), k == n - 1);
		end
	endtask

	// Drop vertices anywhere in the coordinate range
	task automatic send_scatter_query();
		int n;
		n = $urandom_range(1, 8);
		for (int k = 0; k < n; k++)
			send_vertex(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
				coord_t'($urandom), k == n - 1);
	endtask

	task automatic test_extremes();
		send_vertex(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0);
		send_vertex(16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh8000, 1'b0);
		send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1);
		send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 1'b0);
		send_vertex(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0);
		send_vertex(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0);
		send_vertex(16'sh0000, 16'sh0000, 16'sh8000, 16'sh7FFF, 1'b1);
	endtask

	// Offsets on each axis, plus a vertex on top of the point
	task automatic test_axes_and_coincident();
		send_vertex(16'sd100, -16'sd200, 16'sd100, -16'sd200, 1'b0);
		send_vertex(16'sd0, 16'sd0, 16'sd900, -16'sd200, 1'b0);
		send_vertex(16'sd0, 16'sd0, 16'sd100, 16'sd500, 1'b0);
		send_vertex(16'sd0, 16'sd0, -16'sd700, -16'sd200, 1'b0);
		send_vertex(16'sd0, 16'sd0, 16'sd100, -16'sd900, 1'b0);
		send_vertex(16'sd0, 16'sd0, 16'sd100, -16'sd200, 1'b1);
	endtask

	task automatic test_single_vertex();
		send_vertex(16'sd5, 16'sd5, -16'sd3000, 16'sd12, 1'b1);
		send_vertex(16'sd5, 16'sd5, 16'sd5, 16'sd5, 1'b1);
	endtask

	// Point fields on later beats must not move the held point
	task automatic test_held_point();
		send_vertex(16'sd0, 16'sd0, 16'sd10, 16'sd10, 1'b0);
		send_vertex(16'sh7FFF, 16'sh8000, -16'sd10, 16'sd10, 1'b0);
		send_vertex(16'sh8000, 16'sh7FFF, -16'sd10, -16'sd10, 1'b0);
		send_vertex(16'sd30, 16'sd30, 16'sd10, -16'sd10, 1'b1);
	endtask

	// Exact half-turn steps count as negative half turns
	task automatic test_half_turn_step();
		send_vertex(16'sd0, 16'sd0, 16'sd1, 16'sd0, 1'b0);
		send_vertex(16'sd0, 16'sd0, -16'sd1, 16'sd0, 1'b1);
	endtask

	// Circle a triangle many times in one query
	task automatic test_many_turns();
		for (int t = 0; t < 40; t++) begin
			send_vertex(16'sd0, 16'sd0, 16'sd20000, 16'sd0, 1'b0);
			send_vertex(16'sd0, 16'sd0, -16'sd10000, 16'sd17321, 1'b0);
			send_vertex(16'sd0, 16'sd0, -16'sd10000, -16'sd17321, t == 39);
		end
	endtask

	task automatic test_random_queries();
		int start_count;
		start_count = vertices_sent;
		while (vertices_sent - start_count < RANDOM_VERTICES) begin
			calm = (vertices_sent - start_count > 400) && (vertices_sent - start_count < 700);
			if ($urandom_range(0, 99) < 80)
				send_winding_query();
			else
				send_scatter_query();
		end
		calm = 1'b0;
	endtask

	// Stall the result side at random
	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(0, 99) < 10);

	// Check each result beat against the oldest pending query
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (inside_expected.size() == 0) begin
				if (fail_count < 10)
					$display("inside_res beat with no query pending: got %0b", inside_res);
				fail_count++;
			end else if (inside_res !== inside_expected[0]) begin
				if (fail_count < 10)
					$display("inside_res mismatch: expected %0b, got %0b",
						inside_expected[0], inside_res);
				fail_count++;
				void'(inside_expected.pop_front());
			end else begin
				void'(inside_expected.pop_front());
			end
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_axes_and_coincident();
		test_single_vertex();
		test_held_point();
		test_half_turn_step();
		test_many_turns();
		test_random_queries();
		in_valid <= 1'b0;
		while (inside_expected.size() != 0)
			@(posedge clk);
		repeat (ANGLE_BITS + 12) @(posedge clk);
		if (fail_count == 0 && inside_expected.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#12000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
